// ----- rtl/gcdp_pkg.sv -----
// ----------------------------------------------------------------------------
// gcdp_pkg
// Shared types and constants of the grid changepoint dynamic program.
// ----------------------------------------------------------------------------
package gcdp_pkg;

    localparam int GRID_CELLS = 256;
    localparam int CELL_BITS  = $clog2(GRID_CELLS);
    localparam int TIME_BITS  = 24;

    localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;

    localparam logic CFG_LAG_GAIN = 1'b0;
    localparam logic CFG_PENALTY  = 1'b1;

    typedef struct packed {
        logic signed [15:0] grid_value;
        logic signed [15:0] lag_value;
        logic               first_column;
        logic               column_end;
    } gcdp_in_t;

    typedef struct packed {
        logic        [23:0] time_index;
        logic        [23:0] changepoint;
        logic signed [39:0] best_score;
    } gcdp_out_t;

endpackage

// ----- rtl/grid_changepoint_dp_top.sv -----
// ----------------------------------------------------------------------------
// grid_changepoint_dp_top
// Discretised changepoint dynamic program, one grid cell per input word.
//
// Channels: s_ input words (grid value, lag, column flags), m_ result words
// (time, changepoint, best score), cfg_ register writes (0 lag_gain,
// 1 penalty), each valid/ready.
// A first-column word skips the arithmetic and only stores its grid value.
// For a later word, separate shift/subtract units run a 32-step square root and then a
// 58-step restoring division after one setup step, one bit per cycle.
// A column end adds an end step.
// A later-column column-end word loads the result register; m_valid then holds until
// taken, and the next word is accepted meanwhile, but its own column end
// waits until the register is free.
// After reset a clearing pass over all 256 cells zeroes score and start memories;
// s_ready stays low during it. Configuration writes are taken at any time.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
module grid_changepoint_dp_top
    import gcdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  gcdp_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output gcdp_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_PREP, ST_MUL, ST_SQRT, ST_DIV,
        ST_UPDATE, ST_END, ST_STORE
    } state_t;

    state_t state_reg;

    logic signed [39:0] score_mem [GRID_CELLS];
    logic [TIME_BITS-1:0] start_mem [GRID_CELLS];
    logic signed [15:0] prev_mem [GRID_CELLS];

    logic signed [23:0] lag_gain_reg;
    logic signed [39:0] penalty_reg;
    logic [CELL_BITS-1:0] cell_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic signed [39:0] colmax_reg;
    logic [TIME_BITS-1:0] argstart_reg;
    logic signed [39:0] restart_reg;
    logic max_valid_reg;

    gcdp_in_t item_reg;
    logic signed [39:0] score_rd_reg;
    logic [TIME_BITS-1:0] start_rd_reg;
    logic signed [15:0] prev_rd_reg;

    logic signed [41:0] num_reg;
    logic signed [47:0] qq_reg;
    logic signed [47:0] qp_reg;
    logic [63:0] sq_x_reg;
    logic [63:0] sq_res_reg;
    logic [63:0] sq_bit_reg;
    logic [5:0]  step_reg;
    logic [57:0] dv_num_reg;
    logic [57:0] dv_rem_reg;
    logic [57:0] dv_quo_reg;
    logic [31:0] root_reg;
    logic        neg_reg;

    gcdp_out_t out_reg;
    logic      out_valid_reg;

    logic [64:0] sq_try;
    logic [58:0] dv_try;
    logic signed [63:0] term_full;
    logic signed [39:0] term;
    logic signed [39:0] base_score;
    logic signed [40:0] sum_w;
    logic signed [39:0] new_score;
    logic [TIME_BITS-1:0] new_start;
    logic signed [40:0] rl_sum;
    logic signed [39:0] rl_sat;
    logic               out_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_load  = (state_reg == ST_END) && !item_reg.first_column
                       && (!out_valid_reg || m_ready);

    assign sq_try = {1'b0, sq_x_reg} - {1'b0, sq_res_reg + sq_bit_reg};
    assign dv_try = {dv_rem_reg[56:0], dv_num_reg[57]} - {27'd0, root_reg};

    always_comb begin
        term_full = neg_reg ? -$signed({6'd0, dv_quo_reg}) : $signed({6'd0, dv_quo_reg});
        if (root_reg == 32'd0) begin
            if (num_reg > 0) begin
                term = S40_MAX;
            end else if (num_reg < 0) begin
                term = S40_MIN;
            end else begin
                term = '0;
            end
        end else if (term_full > 64'(S40_MAX)) begin
            term = S40_MAX;
        end else if (term_full < 64'(S40_MIN)) begin
            term = S40_MIN;
        end else begin
            term = term_full[39:0];
        end
        if (score_rd_reg <= restart_reg) begin
            base_score = restart_reg;
            new_start  = time_reg;
        end else begin
            base_score = score_rd_reg;
            new_start  = start_rd_reg;
        end
        sum_w = 41'(base_score) + 41'(term);
        if (sum_w > 41'(S40_MAX)) begin
            new_score = S40_MAX;
        end else if (sum_w < 41'(S40_MIN)) begin
            new_score = S40_MIN;
        end else begin
            new_score = sum_w[39:0];
        end
        rl_sum = 41'(penalty_reg) + 41'(colmax_reg);
        if (rl_sum > 41'(S40_MAX)) begin
            rl_sat = S40_MAX;
        end else if (rl_sum < 41'(S40_MIN)) begin
            rl_sat = S40_MIN;
        end else begin
            rl_sat = rl_sum[39:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            score_rd_reg <= score_mem[cell_reg];
            start_rd_reg <= start_mem[cell_reg];
            prev_rd_reg  <= prev_mem[cell_reg];
        end
        if (state_reg == ST_CLEAR) begin
            score_mem[cell_reg] <= '0;
            start_mem[cell_reg] <= '0;
        end else if (state_reg == ST_UPDATE) begin
            score_mem[cell_reg] <= new_score;
            start_mem[cell_reg] <= new_start;
        end
        if (state_reg == ST_STORE) begin
            prev_mem[cell_reg] <= item_reg.grid_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            lag_gain_reg  <= '0;
            penalty_reg   <= '0;
            cell_reg      <= '0;
            time_reg      <= '0;
            colmax_reg    <= S40_MIN;
            argstart_reg  <= '0;
            restart_reg   <= '0;
            max_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_LAG_GAIN) begin
                    lag_gain_reg <= cfg_data[23:0];
                end else begin
                    penalty_reg <= cfg_data;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    cell_reg <= cell_reg + 1'b1;
                    if (cell_reg == CELL_BITS'(GRID_CELLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= s_data.first_column ? ST_STORE : ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_PREP;
                end
                ST_PREP: begin
                    num_reg <= 42'(item_reg.grid_value) * 42'sd4
                        + 42'((48'(lag_gain_reg) * 48'(item_reg.lag_value)) >>> 12);
                    qq_reg  <= 48'(lag_gain_reg) * 48'(lag_gain_reg);
                    qp_reg  <= 48'(lag_gain_reg) * 48'(prev_rd_reg);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    sq_x_reg  <= (64'sh1_0000_0000 + 64'(qq_reg) + (64'(qp_reg) <<< 3) > 0)
                        ? 64'(64'sh1_0000_0000 + 64'(qq_reg) + (64'(qp_reg) <<< 3)) : 64'd0;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                    step_reg   <= '0;
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (!sq_try[64]) begin
                        sq_x_reg   <= sq_try[63:0];
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    step_reg   <= step_reg + 1'b1;
                    if (step_reg == 6'd31) begin
                        step_reg  <= '0;
                        neg_reg   <= num_reg[41];
                        dv_num_reg <= {num_reg[41] ? 42'(-num_reg) : 42'(num_reg), 16'd0};
                        dv_rem_reg <= '0;
                        dv_quo_reg <= '0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (step_reg == 6'd0) begin
                        root_reg <= sq_res_reg[31:0];
                        step_reg <= 6'd1;
                    end else begin
                        dv_num_reg <= dv_num_reg << 1;
                        if (!dv_try[58]) begin
                            dv_rem_reg <= dv_try[57:0];
                            dv_quo_reg <= {dv_quo_reg[56:0], 1'b1};
                        end else begin
                            dv_rem_reg <= {dv_rem_reg[56:0], dv_num_reg[57]};
                            dv_quo_reg <= {dv_quo_reg[56:0], 1'b0};
                        end
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == 6'd58) begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE: begin
                    if (!max_valid_reg || new_score > colmax_reg) begin
                        colmax_reg   <= new_score;
                        argstart_reg <= new_start;
                    end
                    max_valid_reg <= 1'b1;
                    state_reg <= ST_STORE;
                end
                ST_STORE: begin
                    cell_reg <= cell_reg + 1'b1;
                    state_reg <= item_reg.column_end ? ST_END : ST_IDLE;
                end
                ST_END: begin
                    if (item_reg.first_column) begin
                        restart_reg <= penalty_reg;
                    end else if (!out_valid_reg || m_ready) begin
                        out_reg.time_index  <= 24'(time_reg);
                        out_reg.changepoint <= 24'(argstart_reg);
                        out_reg.best_score  <= colmax_reg;
                        restart_reg         <= rl_sat;
                    end
                    if (item_reg.first_column || !out_valid_reg || m_ready) begin
                        colmax_reg    <= S40_MIN;
                        argstart_reg  <= '0;
                        max_valid_reg <= 1'b0;
                        cell_reg      <= '0;
                        time_reg      <= time_reg + 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_cell_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_END && $past(state_reg) == ST_END |-> out_valid_reg)
        else $error("end stalled without pending result");

endmodule

// ----- tb/sv/grid_changepoint_dp_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_changepoint_dp_top_test
// Drives grid cell words through the changepoint dynamic program with random
// idling on both channels. A predictor mirrors the per-cell scores, restarts
// and column maximum, and every result word is checked field by field.
// ----------------------------------------------------------------------------
module grid_changepoint_dp_top_test;
    import gcdp_pkg::*;

    localparam int SETTLE = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    gcdp_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    gcdp_out_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [39:0] cfg_data;

    grid_changepoint_dp_top u_dut (.*);

    gcdp_in_t  cell_words[$];
    gcdp_out_t column_results[$];
    int        mismatches;
    int        accepted;
    bit        quiet;
    bit        hold_send;
    bit        in_fire;

    // predictor state
    logic signed [23:0] gain_q;
    logic signed [39:0] pen_q;
    logic signed [39:0] score_q[GRID_CELLS];
    logic [23:0]        start_q[GRID_CELLS];
    logic signed [15:0] prev_q[GRID_CELLS];
    int                 cell_q;
    logic [23:0]        time_q;
    logic signed [39:0] max_q;
    logic [23:0]        arg_q;
    logic signed [39:0] restart_q;
    bit                 max_seen;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint sat_score(longint v);
        if (v > longint'(S40_MAX)) return longint'(S40_MAX);
        if (v < longint'(S40_MIN)) return longint'(S40_MIN);
        return v;
    endfunction

    function automatic longint root_of(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint cell_gain_term(longint m, longint p, longint lag);
        longint q;
        longint num;
        longint rad;
        longint rt;
        q   = gain_q;
        num = m * 4 + ((q * lag) >>> 12);
        rad = (64'sd1 <<< 32) + q * q + 8 * q * p;
        rt  = (rad <= 0) ? 0 : root_of(rad);
        if (rt == 0) begin
            if (num > 0) return longint'(S40_MAX);
            if (num < 0) return longint'(S40_MIN);
            return 0;
        end
        return sat_score((num * 65536) / rt);
    endfunction

    task automatic predict_column(gcdp_in_t w);
        longint t;
        gcdp_out_t r;
        if (!w.first_column) begin
            t = cell_gain_term(w.grid_value, prev_q[cell_q], w.lag_value);
            if (score_q[cell_q] <= restart_q) begin
                score_q[cell_q] = restart_q;
                start_q[cell_q] = time_q;
            end
            score_q[cell_q] = sat_score(longint'(score_q[cell_q]) + t);
            if (!max_seen || score_q[cell_q] > max_q) begin
                max_q = score_q[cell_q];
                arg_q = start_q[cell_q];
                max_seen = 1'b1;
            end
        end
        prev_q[cell_q] = w.grid_value;
        cell_q = (cell_q + 1) % GRID_CELLS;
        if (w.column_end) begin
            if (w.first_column) begin
                restart_q = pen_q;
            end else begin
                r.time_index  = time_q;
                r.changepoint = arg_q;
                r.best_score  = max_q;
                column_results = {column_results, r};
                restart_q = sat_score(longint'(pen_q) + longint'(max_q));
            end
            max_q = S40_MIN;
            arg_q = '0;
            max_seen = 1'b0;
            cell_q = 0;
            time_q = time_q + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
    end

    // driver
    int send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else if (in_fire) begin
            predict_column(s_data);
            accepted++;
            if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
            if (cell_words.size() > 0 && send_gap == 0 && !hold_send) begin
                s_data <= cell_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (cell_words.size() > 0 && !hold_send) begin
                s_data  <= cell_words.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // sink idling
    int sink_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(1, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        gcdp_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (column_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_data);
            end else begin
                e = column_results.pop_front();
                if (m_data.time_index !== e.time_index
                    || m_data.changepoint !== e.changepoint
                    || m_data.best_score !== e.best_score) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%0d cp=%0d s=%0d got t=%0d cp=%0d s=%0d",
                                 e.time_index, e.changepoint, e.best_score,
                                 m_data.time_index, m_data.changepoint,
                                 m_data.best_score);
                end
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [39:0] v);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_LAG_GAIN) gain_q = v[23:0];
        else pen_q = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cell_words.size() > 0 || s_valid || column_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic gcdp_in_t make_word(bit first, bit last, bit wide);
        gcdp_in_t w;
        w.grid_value   = wide ? 16'($urandom) : 16'($urandom_range(0, 32767) - 16384);
        w.lag_value    = 16'($urandom);
        w.first_column = first;
        w.column_end   = last;
        return w;
    endfunction

    // one column of n cells; first column must cover all later columns' cells
    task automatic queue_column(int n, bit first);
        for (int i = 0; i < n; i++)
            cell_words = {cell_words,
                          make_word(first, i == n - 1, $urandom_range(0, 3) == 0)};
    endtask

    logic signed [23:0] gains[5];
    logic signed [39:0] pens[5];

    initial begin
        gcdp_in_t w;
        int n;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAG_GAIN;
        cfg_data  = '0;
        mismatches = 0;
        accepted  = 0;
        quiet     = 1'b0;
        hold_send = 1'b0;
        gain_q = '0;
        pen_q  = '0;
        for (int i = 0; i < GRID_CELLS; i++) begin
            score_q[i] = '0;
            start_q[i] = '0;
            prev_q[i]  = '0;
        end
        cell_q = 0;
        time_q = '0;
        max_q  = S40_MIN;
        arg_q  = '0;
        restart_q = '0;
        max_seen  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: full-width first column, then extremes
        write_reg(CFG_LAG_GAIN, 40'sd65536);
        write_reg(CFG_PENALTY, 40'sd0);
        for (int i = 0; i < GRID_CELLS; i++) begin
            w = make_word(1'b1, i == GRID_CELLS - 1, 1'b1);
            if (i == 0) w.grid_value = 16'sh7FFF;
            if (i == 1) w.grid_value = 16'sh8000;
            cell_words = {cell_words, w};
        end
        w = '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0}; cell_words = {cell_words, w};
        w = '{16'sh8000, 16'sh8000, 1'b0, 1'b0}; cell_words = {cell_words, w};
        w = '{16'sh0000, 16'sh0000, 1'b0, 1'b1}; cell_words = {cell_words, w};
        queue_column(4, 1'b0);
        drain();
        // large gain with maximum penalty
        write_reg(CFG_LAG_GAIN, 40'sh7F_FFFF);
        write_reg(CFG_PENALTY, 40'sh7F_FFFF_FFFF);
        w = '{16'sh0001, 16'sh7FFF, 1'b0, 1'b0}; cell_words = {cell_words, w};
        w = '{16'sh8000, 16'sh8000, 1'b0, 1'b0}; cell_words = {cell_words, w};
        w = '{16'sh0000, 16'sh0000, 1'b0, 1'b1}; cell_words = {cell_words, w};
        drain();
        write_reg(CFG_LAG_GAIN, 40'shFF_800000);
        write_reg(CFG_PENALTY, 40'sh80_0000_0000);
        queue_column(3, 1'b0);
        w = '{16'sh1234, 16'sh0FFF, 1'b1, 1'b1}; cell_words = {cell_words, w};
        drain();

        gains = '{24'sd0, 24'sh7FFFFF, -24'sd8388608, 24'sd13107, -24'sd6554};
        pens  = '{40'sd0, 40'sh7F_FFFF_FFFF, 40'sh80_0000_0000, 40'sd655360, -40'sd98304};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_LAG_GAIN, ph < 5 ? {{16{gains[ph][23]}}, gains[ph]}
                                           : 40'($signed(24'($urandom))));
            write_reg(CFG_PENALTY, ph < 5 ? pens[ph] : {8'($urandom), 32'($urandom)});
            if (ph == 5) quiet = 1'b1;
            n = 0;
            while (n < 180) begin
                int len;
                if ($urandom_range(0, 19) == 0) len = $urandom_range(250, 258);
                else len = $urandom_range(1, 6);
                queue_column(len, 1'b0);
                n += len;
                if (ph == 2 && n > 100 && !hold_send) begin
                    hold_send = 1'b1;
                    while (column_results.size() > 0 || s_valid) @(posedge aclk);
                    hold_send = 1'b0;
                end
            end
            drain();
        end

        if (mismatches == 0 && column_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
